FILE: src/stripe_beep_blink_indicator_assert.svh
// Assertion macros, clocked on i_clk and held off during reset
`ifndef STRIPE_BEEP_BLINK_INDICATOR_ASSERT_SVH
`define STRIPE_BEEP_BLINK_INDICATOR_ASSERT_SVH

// same-cycle implication
`define SBB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SBB_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/sbb_ind_pkg.sv
`timescale 1ns / 1ps
package sbb_ind_pkg;

    localparam int unsigned OP_W     = 2;
    localparam int unsigned CNT_W    = 4;
    localparam int unsigned COL_W    = 8;
    localparam int unsigned RGB_W    = 3 * COL_W;
    localparam int unsigned PERIOD_W = 16;
    localparam int unsigned TOGG_W   = 8;
    localparam int unsigned BEEPS_W  = 5;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [PERIOD_W-1:0] BEEP_PERIOD_RST  = 16'd100;
    localparam logic [PERIOD_W-1:0] BLINK_PERIOD_RST = 16'd500;
    localparam logic [TOGG_W-1:0]   BLINK_TOGG_RST   = 8'd16;

    localparam logic [RGB_W-1:0] RGB_BLACK = 24'h000000;
    localparam logic [RGB_W-1:0] RGB_WHITE = 24'hFFFFFF;

    typedef enum logic [OP_W-1:0] {
        OP_TICK   = 2'd0,
        OP_STRIPE = 2'd1,
        OP_BLINK  = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BEEP_PERIOD  = 2'd0,
        CFG_BLINK_PERIOD = 2'd1,
        CFG_BLINK_TOGG   = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'b001,
        MODE_BEEP  = 3'b010,
        MODE_BLINK = 3'b100
    } t_mode;

    function automatic logic [RGB_W-1:0] stripe_rgb(input logic [CNT_W-1:0] cnt);
        logic [RGB_W-1:0] rgb;
        case (cnt)
            4'd1:    rgb = 24'hFF0000;
            4'd2:    rgb = 24'h00FF00;
            4'd3:    rgb = 24'hFFFF00;
            4'd4:    rgb = 24'h0000FF;
            4'd5:    rgb = 24'h800080;
            4'd6:    rgb = 24'h00FFFF;
            default: rgb = RGB_BLACK;
        endcase
        return rgb;
    endfunction

endpackage

FILE: src/sbb_in_if.sv
`timescale 1ns / 1ps
interface sbb_in_if;
    logic                           valid;
    logic                           ready;
    logic [sbb_ind_pkg::OP_W-1:0]   op;
    logic [sbb_ind_pkg::CNT_W-1:0]  stripe_count;

    modport source (output valid, output op, output stripe_count, input ready);
    modport sink   (input valid, input op, input stripe_count, output ready);
endinterface

FILE: src/sbb_out_if.sv
`timescale 1ns / 1ps
interface sbb_out_if;
    logic                           valid;
    logic                           ready;
    logic                           buzzer_on;
    logic [sbb_ind_pkg::COL_W-1:0]  red;
    logic [sbb_ind_pkg::COL_W-1:0]  green;
    logic [sbb_ind_pkg::COL_W-1:0]  blue;
    logic                           busy_res;

    modport source (output valid, output buzzer_on, output red, output green,
                    output blue, output busy_res, input ready);
    modport sink   (input valid, input buzzer_on, input red, input green,
                    input blue, input busy_res, output ready);
endinterface

FILE: src/stripe_beep_blink_indicator.sv
`timescale 1ns / 1ps
// channel  | direction | handshake          | payload
// i_in     | sink      | valid / ready      | op, stripe_count
// o_out    | source    | valid / ready      | buzzer_on, red, green, blue, busy_res
// i_cfg_*  | sink      | i_cfg_we only      | i_cfg_idx, i_cfg_data
//
// One item per cycle sustained while the result is taken; items pass the input register
// then the result register; an item's state updates as it enters the result register.
// Synchronous active-low reset clears both stage valids and all sequence state, and
// restores the config defaults.
// A stalled result holds the pipe; the input register still takes one item while the
// result waits, then ready drops until the result is taken.
module stripe_beep_blink_indicator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [sbb_ind_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [sbb_ind_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    sbb_in_if.sink                              i_in,
    sbb_out_if.source                           o_out
);

    `include "stripe_beep_blink_indicator_assert.svh"

    logic [sbb_ind_pkg::PERIOD_W-1:0] r_beep_period;
    logic [sbb_ind_pkg::PERIOD_W-1:0] r_blink_period;
    logic [sbb_ind_pkg::TOGG_W-1:0]   r_blink_togg;

    logic                             r_in_valid;
    sbb_ind_pkg::t_op                 r_op;
    logic [sbb_ind_pkg::CNT_W-1:0]    r_cnt;

    logic                             r_out_valid;
    logic                             r_out_buzz;
    logic [sbb_ind_pkg::RGB_W-1:0]    r_out_rgb;
    logic                             r_out_busy;

    sbb_ind_pkg::t_mode               r_mode,        n_mode;
    logic [sbb_ind_pkg::PERIOD_W-1:0] r_elapsed,     n_elapsed;
    logic [sbb_ind_pkg::CNT_W-1:0]    r_target,      n_target;
    logic [sbb_ind_pkg::BEEPS_W-1:0]  r_beeps_done,  n_beeps_done;
    logic                             r_buzz,        n_buzz;
    logic [sbb_ind_pkg::TOGG_W-1:0]   r_blink_done,  n_blink_done;
    logic                             r_phase,       n_phase;
    logic [sbb_ind_pkg::RGB_W-1:0]    r_rgb,         n_rgb;

    logic                             adv;
    logic                             in_take;
    logic [sbb_ind_pkg::PERIOD_W-1:0] el_inc;

    assign adv     = r_in_valid && (!r_out_valid || o_out.ready);
    assign in_take = i_in.valid && i_in.ready;

    assign i_in.ready      = !r_in_valid || adv;
    assign o_out.valid     = r_out_valid;
    assign o_out.buzzer_on = r_out_buzz;
    assign o_out.red       = r_out_rgb[23:16];
    assign o_out.green     = r_out_rgb[15:8];
    assign o_out.blue      = r_out_rgb[7:0];
    assign o_out.busy_res  = r_out_busy;

    assign el_inc = (r_elapsed == {sbb_ind_pkg::PERIOD_W{1'b1}}) ? r_elapsed
                                                                : r_elapsed + 16'd1;

    always_comb begin
        n_mode       = r_mode;
        n_elapsed    = r_elapsed;
        n_target     = r_target;
        n_beeps_done = r_beeps_done;
        n_buzz       = r_buzz;
        n_blink_done = r_blink_done;
        n_phase      = r_phase;
        n_rgb        = r_rgb;
        unique case (r_op)
            sbb_ind_pkg::OP_TICK: begin
                unique case (r_mode)
                    sbb_ind_pkg::MODE_BEEP: begin
                        if (el_inc >= r_beep_period) begin
                            n_elapsed = '0;
                            if (r_buzz) begin
                                n_buzz = 1'b0;
                                if (r_beeps_done != 5'd31) begin
                                    n_beeps_done = r_beeps_done + 5'd1;
                                end
                                if (n_beeps_done >= {1'b0, r_target}) begin
                                    n_mode = sbb_ind_pkg::MODE_IDLE;
                                end
                            end else begin
                                n_buzz = 1'b1;
                            end
                        end else begin
                            n_elapsed = el_inc;
                        end
                    end
                    sbb_ind_pkg::MODE_BLINK: begin
                        if (el_inc >= r_blink_period) begin
                            n_elapsed = '0;
                            n_phase   = !r_phase;
                            n_rgb     = n_phase ? sbb_ind_pkg::RGB_WHITE
                                                : sbb_ind_pkg::RGB_BLACK;
                            n_buzz    = n_phase;
                            if (r_blink_done != 8'd255) begin
                                n_blink_done = r_blink_done + 8'd1;
                            end
                            if (n_blink_done >= r_blink_togg) begin
                                n_rgb  = sbb_ind_pkg::RGB_BLACK;
                                n_buzz = 1'b0;
                                n_mode = sbb_ind_pkg::MODE_IDLE;
                            end
                        end else begin
                            n_elapsed = el_inc;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            sbb_ind_pkg::OP_STRIPE: begin
                n_rgb        = sbb_ind_pkg::stripe_rgb(r_cnt);
                n_target     = r_cnt;
                n_beeps_done = '0;
                n_buzz       = 1'b1;
                n_mode       = sbb_ind_pkg::MODE_BEEP;
                n_elapsed    = '0;
            end
            sbb_ind_pkg::OP_BLINK: begin
                n_mode       = sbb_ind_pkg::MODE_BLINK;
                n_blink_done = '0;
                n_phase      = 1'b1;
                n_elapsed    = '0;
                n_rgb        = sbb_ind_pkg::RGB_WHITE;
                n_buzz       = 1'b1;
            end
            sbb_ind_pkg::OP_CLEAR: begin
                n_rgb  = sbb_ind_pkg::RGB_BLACK;
                n_buzz = 1'b0;
                n_mode = sbb_ind_pkg::MODE_IDLE;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beep_period  <= sbb_ind_pkg::BEEP_PERIOD_RST;
            r_blink_period <= sbb_ind_pkg::BLINK_PERIOD_RST;
            r_blink_togg   <= sbb_ind_pkg::BLINK_TOGG_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sbb_ind_pkg::CFG_BEEP_PERIOD:  r_beep_period  <= i_cfg_data;
                sbb_ind_pkg::CFG_BLINK_PERIOD: r_blink_period <= i_cfg_data;
                sbb_ind_pkg::CFG_BLINK_TOGG:   r_blink_togg   <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_op  <= sbb_ind_pkg::t_op'(i_in.op);
            r_cnt <= i_in.stripe_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_buzz <= n_buzz;
            r_out_rgb  <= n_rgb;
            r_out_busy <= (n_mode == sbb_ind_pkg::MODE_BLINK);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= sbb_ind_pkg::MODE_IDLE;
            r_elapsed    <= '0;
            r_target     <= '0;
            r_beeps_done <= '0;
            r_buzz       <= 1'b0;
            r_blink_done <= '0;
            r_phase      <= 1'b0;
            r_rgb        <= sbb_ind_pkg::RGB_BLACK;
        end else if (adv) begin
            r_mode       <= n_mode;
            r_elapsed    <= n_elapsed;
            r_target     <= n_target;
            r_beeps_done <= n_beeps_done;
            r_buzz       <= n_buzz;
            r_blink_done <= n_blink_done;
            r_phase      <= n_phase;
            r_rgb        <= n_rgb;
        end
    end

    `SBB_ASSERT_IMP(a_blink_white, o_out.valid && o_out.busy_res,
        (o_out.buzzer_on == (o_out.red == 8'hFF)) && (o_out.red == o_out.green)
        && (o_out.green == o_out.blue), "blink result not white light with buzzer")
    `SBB_ASSERT_NXT(a_adv_fills, adv, r_out_valid, "advanced item missing from result")
    `SBB_ASSERT_NXT(a_hold_item, r_in_valid && !adv, r_in_valid, "stalled item dropped")
    `SBB_ASSERT_IMP(a_beep_count, r_mode == sbb_ind_pkg::MODE_BEEP,
        (r_beeps_done < {1'b0, r_target}) || (r_beeps_done == 5'd0),
        "beep train ran past its count")

endmodule
